FILE: design/svenc_pkg.sv
// shared types, constants and functions of the signed varint encoder
`default_nettype none
package svenc_pkg;

	localparam int ValueW  = 64;
	localparam int ByteW   = 8;
	localparam int MaxBytes = 10;
	localparam int WordW   = MaxBytes * ByteW;
	localparam int LenW    = 4;
	localparam int FirstShift = 6;
	localparam int GroupW  = 7;

	localparam logic [ByteW-1:0] MarkFf = 8'hFF;
	localparam logic [ByteW-1:0] MarkC0 = 8'hC0;
	localparam logic [ByteW-1:0] Mark80 = 8'h80;

	typedef struct packed {
		logic              neg;
		logic [ValueW-1:0] mag;
	} mag_t;

	typedef struct packed {
		logic              neg;
		logic [LenW-1:0]   len;
		logic [ValueW-1:0] mag;
	} len_t;

	typedef struct packed {
		logic [LenW-1:0]  len;
		logic [WordW-1:0] word;
	} enc_t;

	// number of bytes: one plus the 7-bit groups left from bit 6 upward
	function automatic logic [LenW-1:0] enc_len(input logic [ValueW-1:0] m);
		logic [LenW-1:0] n;
		n = LenW'(MaxBytes);
		for (int k = MaxBytes - 2; k >= 0; k--) begin
			if ((m >> (FirstShift + GroupW * k)) == '0) begin
				n = LenW'(k + 1);
			end
		end
		return n;
	endfunction

	// length marker bits, placed in the low n bytes of the word
	function automatic logic [WordW-1:0] enc_prefix(input logic [LenW-1:0] n);
		logic [WordW-1:0] p;
		p = '0;
		if (n >= LenW'(MaxBytes)) begin
			p[WordW-1 -: ByteW]         = MarkFf;
			p[WordW-ByteW-1 -: ByteW]   = MarkC0;
		end else if (n == LenW'(MaxBytes - 1)) begin
			p[WordW-ByteW-1 -: ByteW]   = MarkFf;
			p[WordW-2*ByteW-1 -: ByteW] = Mark80;
		end else begin
			for (int k = 1; k <= MaxBytes - 2; k++) begin
				if (n == LenW'(k)) begin
					p[ByteW*(k-1) +: ByteW] = ByteW'(MarkFf << (ByteW - k));
				end
			end
		end
		return p;
	endfunction

endpackage
`default_nettype wire

FILE: design/svenc_mag.sv
// stage 1: sign and magnitude of the input value
`default_nettype none
module svenc_mag (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [svenc_pkg::ValueW-1:0]   in_value,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output svenc_pkg::mag_t                     out_data
);

	logic            valid_s1;
	svenc_pkg::mag_t data_s1;

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1.neg <= in_value[svenc_pkg::ValueW-1];
			data_s1.mag <= in_value[svenc_pkg::ValueW-1] ? (~in_value + 1'b1) : in_value;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule
`default_nettype wire

FILE: design/svenc_len.sv
// stage 2: encoded length from the magnitude
`default_nettype none
module svenc_len (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	output logic        in_ready,
	input  svenc_pkg::mag_t in_data,
	output logic        out_valid,
	input  wire logic   out_ready,
	output svenc_pkg::len_t out_data
);

	logic            valid_s2;
	svenc_pkg::len_t data_s2;

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s2.neg <= in_data.neg;
			data_s2.mag <= in_data.mag;
			data_s2.len <= svenc_pkg::enc_len(in_data.mag);
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule
`default_nettype wire

FILE: design/svenc_pack.sv
// stage 3: marker bits, complement and left alignment of the byte string
`default_nettype none
module svenc_pack (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	output logic        in_ready,
	input  svenc_pkg::len_t in_data,
	output logic        out_valid,
	input  wire logic   out_ready,
	output svenc_pkg::enc_t out_data
);

	logic                          valid_s3;
	svenc_pkg::enc_t               data_s3;
	logic [svenc_pkg::WordW-1:0]   raw_word;
	logic [svenc_pkg::WordW-1:0]   flip_word;
	logic [svenc_pkg::LenW-1:0]    pad_bytes;

	assign in_ready = !valid_s3 || out_ready;

	always_comb begin
		raw_word  = svenc_pkg::WordW'(in_data.mag) | svenc_pkg::enc_prefix(in_data.len);
		flip_word = raw_word ^ {svenc_pkg::WordW{in_data.neg}};
		pad_bytes = svenc_pkg::LenW'(svenc_pkg::MaxBytes) - in_data.len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	// first byte ends up in the top byte of the word
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s3.len  <= in_data.len;
			data_s3.word <= flip_word << ({3'b000, pad_bytes} * 7'd8);
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

endmodule
`default_nettype wire

FILE: design/svenc_ser.sv
// output stage: sends the encoded word one byte per transaction
`default_nettype none
module svenc_ser (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	output logic        in_ready,
	input  svenc_pkg::enc_t in_data,
	output logic        out_valid,
	input  wire logic   out_ready,
	output logic [svenc_pkg::ByteW-1:0] out_byte,
	output logic        out_last
);

	logic                        valid_q;
	logic [svenc_pkg::LenW-1:0]  left_q;
	logic [svenc_pkg::WordW-1:0] word_q;
	logic                        final_take;

	assign out_last   = (left_q == svenc_pkg::LenW'(1));
	assign final_take = valid_q && out_ready && out_last;
	assign in_ready   = !valid_q || final_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			left_q  <= '0;
		end else if (in_ready) begin
			valid_q <= in_valid;
			left_q  <= in_data.len;
		end else if (valid_q && out_ready) begin
			left_q  <= left_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			word_q <= in_data.word;
		end else if (valid_q && out_ready) begin
			word_q <= word_q << svenc_pkg::ByteW;
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = word_q[svenc_pkg::WordW-1 -: svenc_pkg::ByteW];

endmodule
`default_nettype wire

FILE: design/signed_varint_encoder_top.sv
// Order-preserving signed varint encoder: 64-bit value in, 1 to 10 bytes out.
//
// Input channel s_*: one transaction carries one signed 64-bit value.
// Output channel m_*: one transaction per encoded byte, most significant
// first; m_tlast marks the final byte of each value's encoding.
// Path: the first byte of a value reaches m_tdata through the input stage,
// two more pipeline stages, then the output register.
// Throughput: one output byte per cycle while m_tready is high; a value of n
// bytes holds the output stage until all n are taken. The three front stages
// take a value every cycle when not stalled and hold up to three more values.
// When the receiver drops m_tready the current byte holds, the stages fill
// up and s_tready falls; nothing is lost or repeated.
// Reset (arst_n low) empties every stage at once; the block has no other
// state and no configuration.
`default_nettype none
module signed_varint_encoder_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic signed [63:0] s_tdata, // [63:0] value
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,        // [7:0] out_byte
	output logic             m_tlast         // last_byte
);

	logic            v1, r1, v2, r2, v3, r3;
	svenc_pkg::mag_t d1;
	svenc_pkg::len_t d2;
	svenc_pkg::enc_t d3;

	svenc_mag u_mag (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_value(s_tdata),
		.out_valid(v1), .out_ready(r1), .out_data(d1)
	);

	svenc_len u_len (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v1), .in_ready(r1), .in_data(d1),
		.out_valid(v2), .out_ready(r2), .out_data(d2)
	);

	svenc_pack u_pack (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v2), .in_ready(r2), .in_data(d2),
		.out_valid(v3), .out_ready(r3), .out_data(d3)
	);

	svenc_ser u_ser (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v3), .in_ready(r3), .in_data(d3),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_byte(m_tdata), .out_last(m_tlast)
	);

endmodule
`default_nettype wire

FILE: design/svenc_chk.sv
// port checker for the signed varint encoder, bound to the top level
`default_nettype none
module svenc_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [7:0]  m_tdata,
	input wire logic        m_tlast
);

	logic first_q;
	logic in_seen_q;

	// next byte shown opens a new encoding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (m_tvalid && m_tready) begin
			first_q <= m_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_seen_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			in_seen_q <= 1'b1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output transaction changed");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && first_q && m_tlast |-> m_tdata[7] != m_tdata[6])
		else $error("one-byte encoding with bad marker");

	a_long: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && first_q && (m_tdata == 8'hFF || m_tdata == 8'h00) |-> !m_tlast)
		else $error("long-form marker on a final byte");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		!in_seen_q |-> !m_tvalid)
		else $error("output before any input transaction");

endmodule

bind signed_varint_encoder_top svenc_chk u_svenc_chk (
	.clk(clk), .arst_n(arst_n),
	.s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire

FILE: tb/signed_varint_encoder_top_tb.sv
// testbench for the signed varint encoder: directed table, then random values, byte-wise checks
`timescale 1ns / 100ps
module signed_varint_encoder_top_tb;

	localparam int StallLimit = 2000;
	localparam int DirRows    = 23;
	localparam int RandItems  = 140;

	typedef struct {
		logic [svenc_pkg::ByteW-1:0] out_byte;
		logic                        last_byte;
	} enc_byte_t;

	// typed_len = 0: row is checked against the encoder prediction
	// otherwise the first typed_len bytes of typed_bytes, from the top, are expected
	typedef struct {
		logic [svenc_pkg::ValueW-1:0] value;
		int                           typed_len;
		logic [svenc_pkg::WordW-1:0]  typed_bytes;
	} stim_row_t;

	logic                                clk;
	logic                                arst_n;
	logic                                s_tvalid;
	logic                                s_tready;
	logic signed [svenc_pkg::ValueW-1:0] s_tdata;  // [63:0] value
	logic                                m_tvalid;
	logic                                m_tready;
	logic [svenc_pkg::ByteW-1:0]         m_tdata;  // [7:0] out_byte
	logic                                m_tlast;  // last_byte

	enc_byte_t enc_byte_q[$];
	int        err_count   = 0;
	int        stall_count = 0;
	logic      no_idle     = 1'b0;

	stim_row_t dir_rows [DirRows] = '{
		'{64'h0000_0000_0000_0000, 1, 80'h8000_0000_0000_0000_0000},
		'{64'hFFFF_FFFF_FFFF_FFFF, 1, 80'h7E00_0000_0000_0000_0000},
		'{64'h0000_0000_0000_003F, 1, 80'hBF00_0000_0000_0000_0000},
		'{64'h7FFF_FFFF_FFFF_FFFF, 10, 80'hFFC0_7FFF_FFFF_FFFF_FFFF},
		'{64'h8000_0000_0000_0000, 10, 80'h003F_7FFF_FFFF_FFFF_FFFF},
		'{64'h0000_0000_0000_0040, 0, '0},
		'{64'hFFFF_FFFF_FFFF_FFC0, 0, '0},
		'{64'hFFFF_FFFF_FFFF_FFBF, 0, '0},
		'{64'h0000_0000_0000_1FFF, 0, '0},
		'{64'h0000_0000_0000_2000, 0, '0},
		'{64'h0000_0000_0010_0000, 0, '0},
		'{64'h0000_0000_07FF_FFFF, 0, '0},
		'{64'h0000_0004_0000_0000, 0, '0},
		'{64'h0000_01FF_FFFF_FFFF, 0, '0},
		'{64'h0001_0000_0000_0000, 0, '0},
		'{64'h007F_FFFF_FFFF_FFFF, 0, '0},
		'{64'h0080_0000_0000_0000, 0, '0},
		'{64'h3FFF_FFFF_FFFF_FFFF, 0, '0},
		'{64'h4000_0000_0000_0000, 0, '0},
		'{64'hC000_0000_0000_0000, 0, '0},
		'{64'hFF80_0000_0000_0000, 0, '0},
		'{64'h5555_5555_5555_5555, 0, '0},
		'{64'hAAAA_AAAA_AAAA_AAAA, 0, '0}
	};

	signed_varint_encoder_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// queue the bytes that one value should encode to
	function automatic void encode_value(input logic [svenc_pkg::ValueW-1:0] v);
		logic                         neg;
		logic [svenc_pkg::ValueW-1:0] mag;
		logic [svenc_pkg::ValueW-1:0] rest;
		logic [svenc_pkg::ByteW-1:0]  lead;
		logic [svenc_pkg::ByteW-1:0]  b [svenc_pkg::MaxBytes];
		int                           nbytes;
		int                           first;
		enc_byte_t                    e;
		neg = v[svenc_pkg::ValueW-1];
		mag = neg ? -v : v;
		nbytes = 1;
		rest = mag >> svenc_pkg::FirstShift;
		while (rest != '0) begin
			rest = rest >> svenc_pkg::GroupW;
			nbytes++;
		end
		if (nbytes >= svenc_pkg::MaxBytes) begin
			nbytes = svenc_pkg::MaxBytes;
			b[0] = svenc_pkg::MarkFf;
			b[1] = svenc_pkg::MarkC0;
			first = 2;
		end else if (nbytes == svenc_pkg::MaxBytes - 1) begin
			b[0] = svenc_pkg::MarkFf;
			b[1] = svenc_pkg::Mark80 | {2'b00, mag[61:56]};
			first = 2;
		end else begin
			lead = 8'hFF >> nbytes;
			lead = ~lead;
			b[0] = lead | svenc_pkg::ByteW'(mag >> (8 * (nbytes - 1)));
			first = 1;
		end
		for (int k = first; k < nbytes; k++) begin
			b[k] = svenc_pkg::ByteW'(mag >> (8 * (nbytes - 1 - k)));
		end
		for (int k = 0; k < nbytes; k++) begin
			e.out_byte  = neg ? ~b[k] : b[k];
			e.last_byte = (k == nbytes - 1);
			enc_byte_q.push_back(e);
		end
	endfunction

	// one input transaction, with random gaps ahead of it
	task automatic send_value(input logic [svenc_pkg::ValueW-1:0] v);
		@(negedge clk);
		while (!no_idle && $urandom_range(0, 99) < 18) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	initial begin
		m_tready = 1'b0;
	end

	always @(negedge clk) begin
		m_tready <= no_idle || ($urandom_range(0, 99) >= 18);
	end

	// output check and watchdog
	always @(posedge clk) begin
		enc_byte_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (enc_byte_q.size() == 0) begin
				err_count++;
				if (err_count <= 10)
					$display("mismatch: unexpected byte %h last %b", m_tdata, m_tlast);
			end else begin
				e = enc_byte_q.pop_front();
				if (m_tdata !== e.out_byte || m_tlast !== e.last_byte) begin
					err_count++;
					if (err_count <= 10)
						$display("mismatch: byte exp %h got %h, last exp %b got %b",
							e.out_byte, m_tdata, e.last_byte, m_tlast);
				end
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_count = 0;
		end else begin
			stall_count++;
			if (stall_count >= StallLimit) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		logic [svenc_pkg::ValueW-1:0] v;
		int                           w;
		enc_byte_t                    e;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[r]) begin
			send_value(dir_rows[r].value);
			if (dir_rows[r].typed_len == 0) begin
				encode_value(dir_rows[r].value);
			end else begin
				for (int k = 0; k < dir_rows[r].typed_len; k++) begin
					e.out_byte  = dir_rows[r].typed_bytes[svenc_pkg::WordW-1-8*k -: svenc_pkg::ByteW];
					e.last_byte = (k == dir_rows[r].typed_len - 1);
					enc_byte_q.push_back(e);
				end
			end
		end

		for (int i = 0; i < RandItems; i++) begin
			// a stretch of back-to-back traffic on both sides
			no_idle = (i >= 60 && i < 100);
			// random width so every encoded length turns up
			w = $urandom_range(0, svenc_pkg::ValueW);
			v = {$urandom, $urandom};
			if (w < svenc_pkg::ValueW)
				v = v & ((64'd1 << w) - 64'd1);
			if ($urandom_range(0, 1) == 1)
				v = -v;
			send_value(v);
			encode_value(v);
		end
		no_idle = 1'b0;
		@(negedge clk);
		s_tvalid <= 1'b0;

		while (enc_byte_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		if (err_count == 0 && enc_byte_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
